// ===== rtl/fqs_pkg.sv =====
// ----------------------------------------------------------------------------
// fqs_pkg
// shared sizes, codes and types of the queue with peek and search
// ----------------------------------------------------------------------------
package fqs_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  // beat field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned DOUT_W   = 32;
  localparam int unsigned FPOS_W   = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PEEK    = 2'd2,
    OP_SEARCH  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // controls broadcast to every cell
  typedef struct packed {
    logic                  shift;
    logic [CNT_W-1:0]      load_idx;
    logic                  load;
    logic [DATA_WIDTH-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== rtl/fqs_cell.sv =====
// ----------------------------------------------------------------------------
// fqs_cell
// one queue slot: loads a new word, takes its neighbour's word on dequeue,
// and compares its word against the search key
// ----------------------------------------------------------------------------
module fqs_cell (
  input  logic                           clk_i,
  input  logic [fqs_pkg::CNT_W-1:0]      index_i,
  input  fqs_pkg::cell_ctrl_t            ctrl_i,
  input  logic [fqs_pkg::DATA_WIDTH-1:0] neighbour_i,
  output logic [fqs_pkg::DATA_WIDTH-1:0] data_o,
  output logic                           match_o
);
  import fqs_pkg::*;

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift) begin
      data_d = neighbour_i;
    end else if (ctrl_i.load && (ctrl_i.load_idx == index_i)) begin
      data_d = ctrl_i.value;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == ctrl_i.value);

endmodule

// ===== rtl/fqs_prio_enc.sv =====
// ----------------------------------------------------------------------------
// fqs_prio_enc
// front-most set bit of the qualified match vector
// ----------------------------------------------------------------------------
module fqs_prio_enc (
  input  logic [fqs_pkg::DEPTH-1:0] match_i,
  output logic                      hit_o,
  output logic [fqs_pkg::IDX_W-1:0] idx_o
);
  import fqs_pkg::*;

  always_comb begin
    idx_o = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_i[i]) begin
        idx_o = IDX_W'(i);
      end
    end
  end

  assign hit_o = |match_i;

endmodule

// ===== rtl/fifo_queue_with_search_core.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_search_core
// bounded first-in first-out queue with peek and search, built as a row of
// cells with the front entry always in cell zero
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one operation per beat: tuser is the operation (enqueue,
//   dequeue, peek, search), tdata holds the word and the peek position.
//   m_axis returns exactly one result beat per operation: the word removed
//   or peeked, the search position, a status and the count afterwards.
// throughput
//   one operation per cycle unless the output stalls; the registered result
//   appears in the cycle after the beat is taken. peek mux, parallel compare
//   in every cell and priority encoder all settle in the cycle it is taken.
// cell row
//   enqueue writes the cell at the current count, dequeue makes every cell
//   take its neighbour's word so the front stays in cell zero.
// reset
//   count and the output valid clear; cell contents stay undefined and are
//   never read before being written.
// stall
//   while m_axis_tready is low a held result blocks s_axis_tready, so no
//   result is lost; a new beat is taken in the same cycle the old leaves.
// ----------------------------------------------------------------------------
module fifo_queue_with_search_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // value [31:0], position [35:32], zero pad [39:36]
  input  logic [fqs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // operation [1:0]
  input  logic [fqs_pkg::OP_W-1:0]        s_axis_tuser,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // data_out [31:0], found_position [35:32], status [37:36], count [42:38],
  // zero pad [47:43]
  output logic [fqs_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready
);
  import fqs_pkg::*;

  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // input beat unpacking
  op_e                   op;
  logic [VALUE_W-1:0]    value;
  logic [POS_W-1:0]      position;
  logic [DATA_WIDTH-1:0] key;
  logic                  s_fire;

  assign op       = op_e'(s_axis_tuser);
  assign value    = s_axis_tdata[VALUE_W-1:0];
  assign position = s_axis_tdata[VALUE_W+POS_W-1:VALUE_W];
  assign key      = DATA_WIDTH'(value);
  assign s_fire   = s_axis_tvalid && s_axis_tready;

  // queue state
  logic [CNT_W-1:0] count_q, count_d;
  logic             full, empty;

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  // cell row
  cell_ctrl_t            ctrl;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      cell_match;
  logic [DEPTH-1:0]      held_match;

  assign ctrl.shift    = s_fire && (op == OP_DEQUEUE) && !empty;
  assign ctrl.load     = s_fire && (op == OP_ENQUEUE) && !full;
  assign ctrl.load_idx = count_q;
  assign ctrl.value    = key;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] neighbour;
    if (g == DEPTH - 1) begin : g_last
      assign neighbour = cell_data[g];
    end else begin : g_mid
      assign neighbour = cell_data[g+1];
    end

    fqs_cell u_cell (
      .clk_i       (clk_i),
      .index_i     (CNT_W'(g)),
      .ctrl_i      (ctrl),
      .neighbour_i (neighbour),
      .data_o      (cell_data[g]),
      .match_o     (cell_match[g])
    );

    // only cells below the count hold live entries
    assign held_match[g] = cell_match[g] && (CNT_W'(g) < count_q);
  end

  // search
  logic             hit;
  logic [IDX_W-1:0] hit_idx;

  fqs_prio_enc u_enc (
    .match_i (held_match),
    .hit_o   (hit),
    .idx_o   (hit_idx)
  );

  // peek mux
  logic [CMP_W-1:0]      pos_ext, cnt_ext;
  logic [DATA_WIDTH-1:0] peek_data;

  assign pos_ext = CMP_W'(position);
  assign cnt_ext = CMP_W'(count_q);

  always_comb begin
    peek_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (pos_ext == CMP_W'(i)) begin
        peek_data = cell_data[i];
      end
    end
  end

  // result of the current beat
  logic [DATA_WIDTH-1:0] res_data;
  logic [FPOS_W-1:0]     res_fpos;
  status_e               res_status;

  always_comb begin
    res_data   = '0;
    res_fpos   = '0;
    res_status = ST_OK;
    count_d    = count_q;
    case (op)
      OP_ENQUEUE: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_DEQUEUE: begin
        if (empty) begin
          res_status = ST_MISS;
        end else begin
          res_data = cell_data[0];
          count_d  = count_q - CNT_W'(1);
        end
      end
      OP_PEEK: begin
        if (pos_ext >= cnt_ext) begin
          res_status = ST_MISS;
        end else begin
          res_data = peek_data;
        end
      end
      OP_SEARCH: begin
        if (hit) begin
          res_fpos = FPOS_W'(hit_idx);
        end else begin
          res_status = ST_MISS;
        end
      end
      default: begin
        res_status = ST_MISS;
      end
    endcase
  end

  // output register
  logic                 out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_data_q <= {5'b0, COUNT_W'(count_d), res_status, res_fpos, DOUT_W'(res_data)};
    end
  end

  assign m_axis_tdata  = out_data_q;
  assign m_axis_tvalid = out_valid_q;

  // checks
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_enq_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (op == OP_ENQUEUE) && !full |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("accepted enqueue did not grow the count");

  a_deq_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (op == OP_DEQUEUE) && !empty |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("accepted dequeue did not shrink the count");

  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[37:36] == ST_FULL) |->
      m_axis_tdata[42:38] == COUNT_W'(DEPTH))
    else $error("full status with a count below depth");

endmodule

// ===== dv/fifo_queue_with_search_core_test.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_search_core_test
// self-checking bench for the queue with peek and search: a short table of
// directed operations, then random operation mixes that fill, drain and
// search the queue, with bursty input beats and a stalling output side
// ----------------------------------------------------------------------------
module fifo_queue_with_search_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fqs_pkg::*;

  localparam int unsigned RANDOM_OPS = 750;

  typedef struct {
    logic [DOUT_W-1:0]  data;
    logic [FPOS_W-1:0]  fpos;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } queue_result_t;

  // one line of the directed table; known rows carry the result typed in
  typedef struct {
    op_e                op;
    bit                 any_value;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
    int                 reps;
    bit                 known;
    queue_result_t      res;
  } plan_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  // value [31:0], position [35:32], zero pad [39:36]
  logic [S_TDATA_W-1:0] s_axis_tdata;
  // operation [1:0]
  logic [OP_W-1:0]      s_axis_tuser;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // data_out [31:0], found_position [35:32], status [37:36], count [42:38],
  // zero pad [47:43]
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;

  // words held by the queue, front first
  logic [DATA_WIDTH-1:0] held_words[$];
  // results still to come out of the block, oldest first
  queue_result_t         awaited_results[$];
  plan_row_t             plan[$];
  int                    burst_left;
  int                    mismatches;

  fifo_queue_with_search_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor: applies one operation to the held words, returns its result
  // ---------------------------------------------------------------------------
  function automatic queue_result_t apply_queue_op(op_e op, logic [VALUE_W-1:0] value,
                                                   logic [POS_W-1:0] pos);
    queue_result_t r;
    logic [DATA_WIDTH-1:0] word;
    bit hit;
    word     = value[DATA_WIDTH-1:0];
    r.data   = '0;
    r.fpos   = '0;
    r.status = ST_OK;
    hit      = 1'b0;
    case (op)
      OP_ENQUEUE: begin
        if (held_words.size() >= DEPTH) r.status = ST_FULL;
        else held_words.push_back(word);
      end
      OP_DEQUEUE: begin
        if (held_words.size() == 0) r.status = ST_MISS;
        else r.data = DOUT_W'(held_words.pop_front());
      end
      OP_PEEK: begin
        // a position equal to the count is already out of range
        if (int'(pos) >= held_words.size()) r.status = ST_MISS;
        else r.data = DOUT_W'(held_words[pos]);
      end
      default: begin
        // front-most match wins
        for (int k = 0; k < held_words.size(); k++) begin
          if (!hit && held_words[k] == word) begin
            r.fpos = FPOS_W'(k);
            hit    = 1'b1;
          end
        end
        if (!hit) r.status = ST_MISS;
      end
    endcase
    r.count = COUNT_W'(held_words.size());
    return r;
  endfunction

  function automatic void add_step(op_e op, bit any_value, logic [VALUE_W-1:0] value,
                                   logic [POS_W-1:0] pos, int reps);
    plan_row_t row;
    row.op        = op;
    row.any_value = any_value;
    row.value     = value;
    row.pos       = pos;
    row.reps      = reps;
    row.known     = 1'b0;
    row.res       = '{default: '0, status: ST_OK};
    plan.push_back(row);
  endfunction

  function automatic void add_known(op_e op, logic [VALUE_W-1:0] value, logic [POS_W-1:0] pos,
                                    logic [DOUT_W-1:0] data, logic [FPOS_W-1:0] fpos,
                                    status_e status, logic [COUNT_W-1:0] count);
    plan_row_t row;
    row.op         = op;
    row.any_value  = 1'b0;
    row.value      = value;
    row.pos        = pos;
    row.reps       = 1;
    row.known      = 1'b1;
    row.res.data   = data;
    row.res.fpos   = fpos;
    row.res.status = status;
    row.res.count  = count;
    plan.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // sender: one beat per call, then a gap once the current burst runs out
  // ---------------------------------------------------------------------------
  task automatic send_op(op_e op, logic [VALUE_W-1:0] value, logic [POS_W-1:0] pos,
                         bit known, queue_result_t typed);
    queue_result_t want;
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(S_TDATA_W-VALUE_W-POS_W){1'b0}}, pos, value};
    do @(posedge clk_i); while (!s_axis_tready);
    want = apply_queue_op(op, value, pos);
    // typed-in rows are checked against the table, the predictor only tracks state
    if (known) want = typed;
    awaited_results.push_back(want);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      // idle cycles carry junk that must be ignored
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= S_TDATA_W'({$urandom(), $urandom()});
      s_axis_tuser  <= OP_W'($urandom_range(0, 3));
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off new beats until every result has come out
  task automatic drain_results();
    if (awaited_results.size() != 0) begin
      s_axis_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clk_i);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    queue_result_t      none;
    op_e                op;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
    int                 mode;
    int                 pick;

    none          = '{default: '0, status: ST_OK};
    mismatches    = 0;
    burst_left    = $urandom_range(1, 12);
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue: every read misses
    add_known(OP_DEQUEUE, 32'h0,         4'd0,  32'h0, 4'd0, ST_MISS, 5'd0);
    add_known(OP_PEEK,    32'h0,         4'd0,  32'h0, 4'd0, ST_MISS, 5'd0);
    add_known(OP_SEARCH,  32'h0,         4'd0,  32'h0, 4'd0, ST_MISS, 5'd0);
    // first word into an empty queue is held once
    add_known(OP_ENQUEUE, 32'h0,         4'd15, 32'h0, 4'd0, ST_OK,   5'd1);
    add_known(OP_ENQUEUE, 32'hffff_ffff, 4'd0,  32'h0, 4'd0, ST_OK,   5'd2);
    add_known(OP_PEEK,    32'hffff_ffff, 4'd0,  32'h0, 4'd0, ST_OK,   5'd2);
    add_known(OP_PEEK,    32'h0,         4'd1,  32'hffff_ffff, 4'd0, ST_OK, 5'd2);
    // position equal to count, and the highest position
    add_known(OP_PEEK,    32'h0,         4'd2,  32'h0, 4'd0, ST_MISS, 5'd2);
    add_known(OP_PEEK,    32'h0,         4'd15, 32'h0, 4'd0, ST_MISS, 5'd2);
    add_known(OP_SEARCH,  32'hffff_ffff, 4'd0,  32'h0, 4'd1, ST_OK,   5'd2);
    add_known(OP_SEARCH,  32'h1234_5678, 4'd0,  32'h0, 4'd0, ST_MISS, 5'd2);
    // duplicate word: search reports the front-most one
    add_known(OP_ENQUEUE, 32'hffff_ffff, 4'd0,  32'h0, 4'd0, ST_OK,   5'd3);
    add_known(OP_SEARCH,  32'hffff_ffff, 4'd0,  32'h0, 4'd1, ST_OK,   5'd3);
    add_known(OP_DEQUEUE, 32'h0,         4'd0,  32'h0, 4'd0, ST_OK,   5'd2);
    add_known(OP_SEARCH,  32'hffff_ffff, 4'd0,  32'h0, 4'd0, ST_OK,   5'd2);
    // fill up, then push into a full queue
    add_step(OP_ENQUEUE, 1'b1, 32'h0, 4'd5, 14);
    add_known(OP_ENQUEUE, 32'h5a5a_5a5a, 4'd0,  32'h0, 4'd0, ST_FULL, 5'd16);
    add_step(OP_PEEK, 1'b0, 32'h0, 4'd15, 1);
    add_known(OP_SEARCH,  32'hffff_ffff, 4'd0,  32'h0, 4'd0, ST_OK,   5'd16);
    add_step(OP_PEEK, 1'b0, 32'h0, 4'd8, 1);
    // drain completely, one past empty
    add_step(OP_DEQUEUE, 1'b0, 32'h0, 4'd0, 16);
    add_known(OP_DEQUEUE, 32'h0,         4'd0,  32'h0, 4'd0, ST_MISS, 5'd0);
    add_known(OP_ENQUEUE, 32'ha5a5_5a5a, 4'd0,  32'h0, 4'd0, ST_OK,   5'd1);
    add_known(OP_SEARCH,  32'ha5a5_5a5a, 4'd0,  32'h0, 4'd0, ST_OK,   5'd1);
    add_known(OP_PEEK,    32'h0,         4'd0,  32'ha5a5_5a5a, 4'd0, ST_OK, 5'd1);

    foreach (plan[r]) begin
      for (int i = 0; i < plan[r].reps; i++) begin
        send_op(plan[r].op, plan[r].any_value ? VALUE_W'($urandom()) : plan[r].value,
                plan[r].pos, plan[r].known, plan[r].res);
      end
    end

    // random mixes: fill-leaning, drain-leaning and balanced stretches
    mode = 0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 40 == 0) mode = $urandom_range(0, 2);
      if (n == RANDOM_OPS / 2) drain_results();
      pick = $urandom_range(0, 99);
      case (mode)
        0:       op = (pick < 55) ? OP_ENQUEUE : (pick < 70) ? OP_DEQUEUE :
                      (pick < 85) ? OP_PEEK : OP_SEARCH;
        1:       op = (pick < 15) ? OP_ENQUEUE : (pick < 70) ? OP_DEQUEUE :
                      (pick < 85) ? OP_PEEK : OP_SEARCH;
        default: op = (pick < 30) ? OP_ENQUEUE : (pick < 50) ? OP_DEQUEUE :
                      (pick < 75) ? OP_PEEK : OP_SEARCH;
      endcase
      // small values make duplicates, so searches see several matches
      pick = $urandom_range(0, 99);
      if (pick < 40)      value = VALUE_W'($urandom_range(0, 7));
      else if (pick < 45) value = 32'hffff_ffff;
      else                value = VALUE_W'($urandom());
      if (op == OP_SEARCH && held_words.size() != 0 && $urandom_range(0, 99) < 65) begin
        value = held_words[$urandom_range(0, held_words.size() - 1)];
      end
      if (op == OP_PEEK && held_words.size() != 0 && $urandom_range(0, 99) < 75) begin
        pos = POS_W'($urandom_range(0, held_words.size() - 1));
      end else begin
        pos = POS_W'($urandom_range(0, 15));
      end
      send_op(op, value, pos, 1'b0, none);
    end

    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    // keep watching the output to catch a stray result beat
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[fifo_queue_with_search_core] OK");
    end else begin
      $display("[fifo_queue_with_search_core] ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: ready runs of random length with stalls, now and then a long run
  // ---------------------------------------------------------------------------
  initial begin : result_stalls
    int run_hi;
    int run_lo;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      run_hi = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      run_lo = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
      repeat (run_hi) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
      repeat (run_lo) begin
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every accepted result beat against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    queue_result_t want;
    queue_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.data   = m_axis_tdata[31:0];
      got.fpos   = m_axis_tdata[35:32];
      got.status = status_e'(m_axis_tdata[37:36]);
      got.count  = m_axis_tdata[42:38];
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing awaited: tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (got.data !== want.data) begin
          $error("data_out: expected %h, got %h", want.data, got.data);
          mismatches++;
        end
        if (got.fpos !== want.fpos) begin
          $error("found_position: expected %0d, got %0d", want.fpos, got.fpos);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatches++;
        end
        if (got.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, got.count);
          mismatches++;
        end
      end
    end
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #500_000;
    $display("[fifo_queue_with_search_core] ERROR");
    $finish;
  end

endmodule
